/* rtl/assert_macros.svh */
// Assertion helpers used by the RTL step unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

/* rtl/clais_pkg.sv */
package clais_pkg;

   // Register field codes (opcode bits 2..0 and 5..3)
   localparam logic [2:0] REG_B   = 3'd0;
   localparam logic [2:0] REG_C   = 3'd1;
   localparam logic [2:0] REG_D   = 3'd2;
   localparam logic [2:0] REG_E   = 3'd3;
   localparam logic [2:0] REG_H   = 3'd4;
   localparam logic [2:0] REG_L   = 3'd5;
   localparam logic [2:0] REG_MEM = 3'd6;
   localparam logic [2:0] REG_A   = 3'd7;

   // Opcodes decoded as whole bytes
   localparam logic [7:0] OP_NOP   = 8'h00;
   localparam logic [7:0] OP_LD_BC = 8'h01;
   localparam logic [7:0] OP_LD_DE = 8'h11;
   localparam logic [7:0] OP_LD_HL = 8'h21;
   localparam logic [7:0] OP_LD_SP = 8'h31;

   // Opcode groups
   localparam logic [1:0] GRP_LOAD = 2'b01;   // bits 7..6
   localparam logic [3:0] GRP_ADD  = 4'h8;    // bits 7..4

   // Flag bit positions
   localparam int FLAG_S  = 7;
   localparam int FLAG_Z  = 6;
   localparam int FLAG_Y  = 5;
   localparam int FLAG_H  = 4;
   localparam int FLAG_X  = 3;
   localparam int FLAG_PV = 2;
   localparam int FLAG_N  = 1;
   localparam int FLAG_C  = 0;

   // Cycle costs
   localparam logic [3:0] CYC_SHORT   = 4'd4;
   localparam logic [3:0] CYC_IMM     = 4'd10;
   localparam logic [3:0] CYC_ILLEGAL = 4'd2;

   // Program counter steps
   localparam logic [15:0] PC_STEP_ONE     = 16'd1;
   localparam logic [15:0] PC_STEP_ILLEGAL = 16'd2;
   localparam logic [15:0] PC_STEP_IMM     = 16'd3;

   typedef struct packed {
      logic [15:0] pc;
      logic [15:0] sp;
      logic [7:0]  a;
      logic [7:0]  f;
      logic [7:0]  b;
      logic [7:0]  c;
      logic [7:0]  d;
      logic [7:0]  e;
      logic [7:0]  h;
      logic [7:0]  l;
   } arch_type;

   typedef struct packed {
      logic [7:0] opcode;
      logic [7:0] imm_low;
      logic [7:0] imm_high;
   } instr_type;

   typedef struct packed {
      arch_type   regs;
      logic [3:0] cycles;
      logic       illegal;
   } result_type;

endpackage

/* rtl/clais_if.sv */
interface clais_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] opcode;
   logic [7:0] imm_low;
   logic [7:0] imm_high;

   modport source (output valid, output opcode, output imm_low, output imm_high,
                   input ready);
   modport sink   (input valid, input opcode, input imm_low, input imm_high,
                   output ready);
endinterface

interface clais_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] next_pc;
   logic [15:0] stack_ptr;
   logic [7:0]  acc;
   logic [7:0]  flags;
   logic [7:0]  reg_b;
   logic [7:0]  reg_c;
   logic [7:0]  reg_d;
   logic [7:0]  reg_e;
   logic [7:0]  reg_h;
   logic [7:0]  reg_l;
   logic [3:0]  cycles;
   logic        illegal;

   modport source (output valid, output next_pc, output stack_ptr, output acc,
                   output flags, output reg_b, output reg_c, output reg_d,
                   output reg_e, output reg_h, output reg_l, output cycles,
                   output illegal, input ready);
   modport sink   (input valid, input next_pc, input stack_ptr, input acc,
                   input flags, input reg_b, input reg_c, input reg_d,
                   input reg_e, input reg_h, input reg_l, input cycles,
                   input illegal, output ready);
endinterface

/* rtl/clais_exec.sv */
// Decode one instruction and compute the register set after it.
module clais_exec (
   input  clais_pkg::arch_type  cur,
   input  clais_pkg::instr_type instr,
   output clais_pkg::arch_type  nxt,
   output logic [3:0]           cycles,
   output logic                 illegal
);

   logic [2:0]  src;
   logic [2:0]  dst;
   logic [7:0]  src_val;
   logic        carry_in;
   logic [8:0]  sum;
   logic [7:0]  half;
   logic [15:0] pc_step;
   logic [7:0]  new_f;

   assign src = instr.opcode[2:0];
   assign dst = instr.opcode[5:3];

   // source operand
   always_comb begin
      case (src)
         clais_pkg::REG_B: src_val = cur.b;
         clais_pkg::REG_C: src_val = cur.c;
         clais_pkg::REG_D: src_val = cur.d;
         clais_pkg::REG_E: src_val = cur.e;
         clais_pkg::REG_H: src_val = cur.h;
         clais_pkg::REG_L: src_val = cur.l;
         clais_pkg::REG_A: src_val = cur.a;
         default:          src_val = 8'h00;
      endcase
   end

   // adder: ADC takes the old carry
   assign carry_in = instr.opcode[3] & cur.f[clais_pkg::FLAG_C];
   assign sum  = {1'b0, cur.a} + {1'b0, src_val} + {8'h00, carry_in};
   assign half = cur.a ^ src_val ^ sum[7:0];

   always_comb begin
      new_f                    = 8'h00;
      new_f[clais_pkg::FLAG_S] = sum[7];
      new_f[clais_pkg::FLAG_Z] = (sum[7:0] == 8'h00);
      new_f[clais_pkg::FLAG_Y] = sum[5];
      new_f[clais_pkg::FLAG_H] = half[4];
      new_f[clais_pkg::FLAG_X] = sum[3];
      new_f[clais_pkg::FLAG_PV] = ~(cur.a[7] ^ src_val[7]) & (cur.a[7] ^ sum[7]);
      new_f[clais_pkg::FLAG_N] = 1'b0;
      new_f[clais_pkg::FLAG_C] = sum[8];
   end

   always_comb begin
      nxt     = cur;
      cycles  = clais_pkg::CYC_SHORT;
      pc_step = clais_pkg::PC_STEP_ONE;
      illegal = 1'b0;
      case (instr.opcode)
         clais_pkg::OP_NOP: begin
         end
         clais_pkg::OP_LD_BC: begin
            nxt.b   = instr.imm_high;
            nxt.c   = instr.imm_low;
            cycles  = clais_pkg::CYC_IMM;
            pc_step = clais_pkg::PC_STEP_IMM;
         end
         clais_pkg::OP_LD_DE: begin
            nxt.d   = instr.imm_high;
            nxt.e   = instr.imm_low;
            cycles  = clais_pkg::CYC_IMM;
            pc_step = clais_pkg::PC_STEP_IMM;
         end
         clais_pkg::OP_LD_HL: begin
            nxt.h   = instr.imm_high;
            nxt.l   = instr.imm_low;
            cycles  = clais_pkg::CYC_IMM;
            pc_step = clais_pkg::PC_STEP_IMM;
         end
         clais_pkg::OP_LD_SP: begin
            nxt.sp  = {instr.imm_high, instr.imm_low};
            cycles  = clais_pkg::CYC_IMM;
            pc_step = clais_pkg::PC_STEP_IMM;
         end
         default: begin
            if (instr.opcode[7:6] == clais_pkg::GRP_LOAD &&
                src != clais_pkg::REG_MEM && dst != clais_pkg::REG_MEM) begin
               case (dst)
                  clais_pkg::REG_B: nxt.b = src_val;
                  clais_pkg::REG_C: nxt.c = src_val;
                  clais_pkg::REG_D: nxt.d = src_val;
                  clais_pkg::REG_E: nxt.e = src_val;
                  clais_pkg::REG_H: nxt.h = src_val;
                  clais_pkg::REG_L: nxt.l = src_val;
                  clais_pkg::REG_A: nxt.a = src_val;
                  default:          nxt.a = cur.a;
               endcase
            end else if (instr.opcode[7:4] == clais_pkg::GRP_ADD &&
                         src != clais_pkg::REG_MEM) begin
               nxt.a = sum[7:0];
               nxt.f = new_f;
            end else begin
               illegal = 1'b1;
               cycles  = clais_pkg::CYC_ILLEGAL;
               pc_step = clais_pkg::PC_STEP_ILLEGAL;
            end
         end
      endcase
      nxt.pc = cur.pc + pc_step;
   end

endmodule

/* rtl/cpu_load_add_instruction_step_unit.sv */
// An item enters the input register, then executes into the result register; it
// waits in the input register while the result register is full and not taken.
// One item per cycle unless stalled; the register file feeds back in one pass.
// The only loop is register file -> decode/8-bit add -> register file.
// Reset (synchronous, active high): A, F, B..L, SP and PC clear to zero and both
// pipeline stages empty; the input and result payload registers are not reset.
`include "assert_macros.svh"

module cpu_load_add_instruction_step_unit (
   input  logic         clock,
   input  logic         reset,
   clais_req_if.sink    req_bus,
   clais_rsp_if.source  rsp_bus
);

   // input register
   logic                  in_vld_ff;
   logic                  in_vld_in;
   clais_pkg::instr_type  instr_ff;

   // architectural registers
   clais_pkg::arch_type   state_ff;
   clais_pkg::arch_type   state_in;

   // result register
   logic                  out_vld_ff;
   logic                  out_vld_in;
   clais_pkg::result_type out_ff;

   logic                  exec_fire;
   logic                  req_take;
   logic [3:0]            exec_cycles;
   logic                  exec_illegal;

   // Execute when an item is held and the result slot is free or drains now.
   assign exec_fire = in_vld_ff && (!out_vld_ff || rsp_bus.ready);
   // Take a new item while the input stage is empty or advancing.
   assign req_take  = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !in_vld_ff || exec_fire;

   clais_exec u_exec (
      .cur     (state_ff),
      .instr   (instr_ff),
      .nxt     (state_in),
      .cycles  (exec_cycles),
      .illegal (exec_illegal)
   );

   always_comb begin
      in_vld_in  = req_take || (in_vld_ff && !exec_fire);
      out_vld_in = exec_fire || (out_vld_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         state_ff   <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         // commit the register set only when the item executes
         if (exec_fire) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers: load on accept / execute, hold otherwise
   always_ff @(posedge clock) begin
      if (req_take) begin
         instr_ff.opcode   <= req_bus.opcode;
         instr_ff.imm_low  <= req_bus.imm_low;
         instr_ff.imm_high <= req_bus.imm_high;
      end
      if (exec_fire) begin
         out_ff.regs    <= state_in;
         out_ff.cycles  <= exec_cycles;
         out_ff.illegal <= exec_illegal;
      end
   end

   assign rsp_bus.valid     = out_vld_ff;
   assign rsp_bus.next_pc   = out_ff.regs.pc;
   assign rsp_bus.stack_ptr = out_ff.regs.sp;
   assign rsp_bus.acc       = out_ff.regs.a;
   assign rsp_bus.flags     = out_ff.regs.f;
   assign rsp_bus.reg_b     = out_ff.regs.b;
   assign rsp_bus.reg_c     = out_ff.regs.c;
   assign rsp_bus.reg_d     = out_ff.regs.d;
   assign rsp_bus.reg_e     = out_ff.regs.e;
   assign rsp_bus.reg_h     = out_ff.regs.h;
   assign rsp_bus.reg_l     = out_ff.regs.l;
   assign rsp_bus.cycles    = out_ff.cycles;
   assign rsp_bus.illegal   = out_ff.illegal;

   // A shown result always reflects the current register set.
   `ASSERT_IMP(a_rsp_matches_state, clock, reset, out_vld_ff, out_ff.regs == state_ff)
   // An illegal item costs the short illegal cycle count.
   `ASSERT_IMP(a_illegal_cost, clock, reset, out_vld_ff && out_ff.illegal,
      out_ff.cycles == clais_pkg::CYC_ILLEGAL)
   // Registers change only when an item executes.
   `ASSERT_NXT(a_state_hold, clock, reset, !exec_fire, $stable(state_ff))
   // An executed item always lands in the result register.
   `ASSERT_NXT(a_exec_lands, clock, reset, exec_fire, out_vld_ff)

endmodule
